FILE: rtl/ntcl_pkg.sv
`default_nettype none
package ntcl_pkg;

   // defaults for the top level parameters
   localparam int ADC_BITS_DEFAULT      = 10;
   localparam int FRACTION_BITS_DEFAULT = 8;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REFERENCE_COUNT   = 2'd0,
      CSR_SUPPLY_MILLIVOLTS = 2'd1,
      CSR_UPPER_LIMIT       = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SUPPLY = 2'd1,
      STATUS_SAT    = 2'd2
   } status_type;

   // field widths
   localparam int NODE_W  = 16;
   localparam int RES_W   = 24;
   localparam int TEMP_W  = 16;
   localparam int REF_W   = 10;
   localparam int SUP_W   = 13;
   localparam int LIMIT_W = 7;
   localparam int LOG_W   = 29;
   localparam int MAG_W   = 29;
   localparam int X_W     = 36;
   localparam int TK_W    = 32;
   localparam int RNUM_W  = 30;

   // arithmetic constants
   localparam logic [10:0]      VREF_MV     = 11'd1250;
   localparam logic [16:0]      PULLUP_OHMS = 17'd100000;
   localparam logic [NODE_W-1:0] NODE_MAX   = 16'hFFFF;
   localparam logic [RES_W-1:0] RES_MAX     = 24'hFFFFFF;
   localparam logic [35:0]      KB_Q48      = 36'd49393313039;
   localparam logic [31:0]      XC_Q40      = 32'd3687780070;
   localparam logic [28:0]      KOFF_Q20    = 29'd285894246;
   // above this divisor the kelvin quotient stays below 2^32
   localparam logic [X_W-2:0]   TK_X_MIN    = 35'd268435456;

   // log2 in q.24, used for the fixed pull-up value
   function automatic logic [LOG_W-1:0] log2_q24(input logic [RES_W-1:0] r);
      logic [4:0]  p;
      logic [63:0] m;
      logic [23:0] frac;
      p    = '0;
      frac = '0;
      for (int i = 0; i < RES_W; i++) begin
         if (r[i]) begin
            p = 5'(i);
         end
      end
      m = 64'(r) << (5'd31 - p);
      for (int i = 0; i < 24; i++) begin
         m    = (m * m) >> 31;
         frac = {frac[22:0], 1'b0};
         if (m[32]) begin
            m       = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {p, frac};
   endfunction

   localparam logic [LOG_W-1:0] LOG2_PULLUP = log2_q24(24'(PULLUP_OHMS));

   // sideband carried through the pipeline units
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              supply_hit;
   } res_side_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [RES_W-1:0]  res;
      logic              supply_hit;
   } log_side_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [RES_W-1:0]  res;
      logic              supply_hit;
      logic              temp_sat;
   } tk_side_type;

endpackage
`default_nettype wire

FILE: rtl/ntc_temperature_with_limit.sv
`default_nettype none
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_adc_sample
// rsp      out        rsp_valid/rsp_stall   node, resistance, temperature, over_limit, status
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// one item per cycle while no result waits under rsp_stall; the depth comes from
// the three one-bit-per-stage dividers and the 24 squaring stages of the log2 unit
// reset clears the valid bits and loads the register defaults 384, 4500 and 30
// the whole pipeline holds while a result is waiting under rsp_stall
module ntc_temperature_with_limit #(
   parameter int ADC_BITS      = ntcl_pkg::ADC_BITS_DEFAULT,
   parameter int FRACTION_BITS = ntcl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ADC_BITS-1:0]               req_adc_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ntcl_pkg::NODE_W-1:0]       rsp_node_millivolts,
   output logic [ntcl_pkg::RES_W-1:0]        rsp_resistance_ohms,
   output logic signed [ntcl_pkg::TEMP_W-1:0] rsp_temperature_q8,
   output logic                              rsp_over_limit,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ntcl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ntcl_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ntcl_pkg::*;

   localparam int NUM_W   = ADC_BITS + 11;
   localparam int SHIFT   = 20 - FRACTION_BITS;
   localparam int V_W     = TK_W + 2;
   localparam int CMP_W   = 32;
   localparam logic [V_W-1:0] HALF = V_W'(1) << (SHIFT - 1);
   localparam int TEMP_MAX = 32767;
   localparam int TEMP_MIN = -32768;

   logic advance;

   // configuration registers
   logic [REF_W-1:0]   ref_count_ff;
   logic [SUP_W-1:0]   supply_ff;
   logic [LIMIT_W-1:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_count_ff <= REF_W'(384);
         supply_ff    <= SUP_W'(4500);
         limit_ff     <= LIMIT_W'(30);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REFERENCE_COUNT:   ref_count_ff <= csr_data[REF_W-1:0];
            CSR_SUPPLY_MILLIVOLTS: supply_ff    <= csr_data[SUP_W-1:0];
            CSR_UPPER_LIMIT:       limit_ff     <= csr_data[LIMIT_W-1:0];
            default:               ;
         endcase
      end
   end

   // global hold while the result register is stalled
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // input stage: scale by reference voltage
   logic             s0_valid_ff;
   logic [NUM_W-1:0] s0_num_ff;
   logic             s0_ref_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_num_ff      <= NUM_W'(req_adc_sample) * NUM_W'(VREF_MV);
         s0_ref_zero_ff <= (ref_count_ff == '0);
      end
   end

   // node voltage divider
   logic             nd_valid;
   logic [NUM_W-1:0] nd_quo;
   logic             nd_ref_zero;

   ntcl_div_pipe #(
      .NUM_W  (NUM_W),
      .DEN_W  (REF_W),
      .SIDE_W (1)
   ) u_node_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_num    (s0_num_ff),
      .in_den    (ref_count_ff),
      .in_rem    ('0),
      .in_side   (s0_ref_zero_ff),
      .out_valid (nd_valid),
      .out_quo   (nd_quo),
      .out_side  (nd_ref_zero)
   );

   // node saturation
   logic              s1_valid_ff;
   logic [NODE_W-1:0] s1_node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= nd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (nd_ref_zero || (nd_quo > NUM_W'(NODE_MAX))) begin
            s1_node_ff <= NODE_MAX;
         end else begin
            s1_node_ff <= nd_quo[NODE_W-1:0];
         end
      end
   end

   // resistance numerator and denominator
   logic              s2_valid_ff;
   logic [RNUM_W-1:0] s2_num_ff;
   logic [SUP_W-1:0]  s2_den_ff;
   res_side_type      s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_num_ff             <= RNUM_W'(s1_node_ff[SUP_W-1:0]) * RNUM_W'(PULLUP_OHMS);
         s2_den_ff             <= supply_ff - s1_node_ff[SUP_W-1:0];
         s2_side_ff.node       <= s1_node_ff;
         s2_side_ff.supply_hit <= (s1_node_ff >= NODE_W'(supply_ff));
      end
   end

   // resistance divider
   logic              rd_valid;
   logic [RNUM_W-1:0] rd_quo;
   res_side_type      rd_side;

   ntcl_div_pipe #(
      .NUM_W  (RNUM_W),
      .DEN_W  (SUP_W),
      .SIDE_W ($bits(res_side_type))
   ) u_res_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_rem    ('0),
      .in_side   (s2_side_ff),
      .out_valid (rd_valid),
      .out_quo   (rd_quo),
      .out_side  (rd_side)
   );

   // resistance saturation
   logic         s3_valid_ff;
   log_side_type s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= rd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_side_ff.node       <= rd_side.node;
         s3_side_ff.supply_hit <= rd_side.supply_hit;
         if (rd_side.supply_hit || (rd_quo > RNUM_W'(RES_MAX))) begin
            s3_side_ff.res <= RES_MAX;
         end else begin
            s3_side_ff.res <= rd_quo[RES_W-1:0];
         end
      end
   end

   // log2 of resistance
   logic             lg_valid;
   logic [LOG_W-1:0] lg_log;
   log_side_type     lg_side;

   ntcl_log2_pipe #(
      .SIDE_W ($bits(log_side_type))
   ) u_log2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_value  (s3_side_ff.res),
      .in_side   (s3_side_ff),
      .out_valid (lg_valid),
      .out_log   (lg_log),
      .out_side  (lg_side)
   );

   // log ratio against the pull-up, sign and magnitude
   logic              s4_valid_ff;
   logic [MAG_W-1:0]  s4_mag_ff;
   logic              s4_neg_ff;
   log_side_type      s4_side_ff;
   logic signed [LOG_W:0] s4_diff;

   assign s4_diff = $signed({1'b0, lg_log}) - $signed({1'b0, LOG2_PULLUP});

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= lg_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_neg_ff  <= s4_diff[LOG_W];
         s4_mag_ff  <= s4_diff[LOG_W] ? MAG_W'(-s4_diff) : MAG_W'(s4_diff);
         s4_side_ff <= lg_side;
      end
   end

   // two partial products of magnitude times ln2/beta
   logic         s5_valid_ff;
   logic [46:0]  s5_pp_lo_ff;
   logic [46:0]  s5_pp_hi_ff;
   logic         s5_neg_ff;
   log_side_type s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_pp_lo_ff <= 47'(s4_mag_ff) * 47'(KB_Q48[17:0]);
         s5_pp_hi_ff <= 47'(s4_mag_ff) * 47'(KB_Q48[35:18]);
         s5_neg_ff   <= s4_neg_ff;
         s5_side_ff  <= s4_side_ff;
      end
   end

   // combine partial products, keep bits above 2^32
   logic         s6_valid_ff;
   logic [32:0]  s6_step_ff;
   logic         s6_neg_ff;
   log_side_type s6_side_ff;
   logic [64:0]  s6_full;

   assign s6_full = {s5_pp_hi_ff, 18'b0} + 65'(s5_pp_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_step_ff <= s6_full[64:32];
         s6_neg_ff  <= s5_neg_ff;
         s6_side_ff <= s5_side_ff;
      end
   end

   // reciprocal temperature and range check
   logic                  s7_valid_ff;
   logic [X_W-2:0]        s7_den_ff;
   tk_side_type           s7_side_ff;
   logic signed [X_W-1:0] s7_x;

   assign s7_x = s6_neg_ff ? $signed(X_W'(XC_Q40) - X_W'(s6_step_ff))
                           : $signed(X_W'(XC_Q40) + X_W'(s6_step_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_den_ff             <= s7_x[X_W-2:0];
         s7_side_ff.node       <= s6_side_ff.node;
         s7_side_ff.res        <= s6_side_ff.res;
         s7_side_ff.supply_hit <= s6_side_ff.supply_hit;
         s7_side_ff.temp_sat   <= (s6_side_ff.res == '0) ||
                                  (s7_x <= $signed({1'b0, TK_X_MIN}));
      end
   end

   // kelvin = 2^60 / x, quotient known below 2^32
   logic        td_valid;
   logic [TK_W-1:0] td_quo;
   tk_side_type td_side;

   ntcl_div_pipe #(
      .NUM_W  (TK_W),
      .DEN_W  (X_W - 1),
      .SIDE_W ($bits(tk_side_type))
   ) u_tk_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s7_valid_ff),
      .in_num    ('0),
      .in_den    (s7_den_ff),
      .in_rem    (TK_X_MIN),
      .in_side   (s7_side_ff),
      .out_valid (td_valid),
      .out_quo   (td_quo),
      .out_side  (td_side)
   );

   // celsius offset and rounding to the output fraction
   logic                  s8_valid_ff;
   logic signed [V_W-1:0] s8_q_ff;
   tk_side_type           s8_side_ff;
   logic signed [V_W-1:0] s8_v;

   assign s8_v = $signed({2'b0, td_quo} - V_W'(KOFF_Q20) + HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s8_valid_ff <= td_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_q_ff    <= s8_v >>> SHIFT;
         s8_side_ff <= td_side;
      end
   end

   // saturation, status and limit flag into the result register
   logic                    rsp_valid_ff;
   logic [NODE_W-1:0]       rsp_node_ff;
   logic [RES_W-1:0]        rsp_res_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic                    rsp_over_ff;
   logic [1:0]              rsp_status_ff;
   logic signed [TEMP_W-1:0] temp_in;
   logic                    sat_in;
   logic [1:0]              status_in;
   logic                    over_in;

   always_comb begin
      if (s8_side_ff.temp_sat) begin
         temp_in = TEMP_W'(TEMP_MAX);
         sat_in  = 1'b1;
      end else if (s8_q_ff > V_W'(TEMP_MAX)) begin
         temp_in = TEMP_W'(TEMP_MAX);
         sat_in  = 1'b1;
      end else if (s8_q_ff < $signed(V_W'(TEMP_MIN))) begin
         temp_in = TEMP_W'(TEMP_MIN);
         sat_in  = 1'b1;
      end else begin
         temp_in = s8_q_ff[TEMP_W-1:0];
         sat_in  = 1'b0;
      end
      if (s8_side_ff.supply_hit) begin
         status_in = STATUS_SUPPLY;
      end else if (sat_in) begin
         status_in = STATUS_SAT;
      end else begin
         status_in = STATUS_OK;
      end
      over_in = ($signed({{(CMP_W-TEMP_W){temp_in[TEMP_W-1]}}, temp_in}) >
                 $signed(CMP_W'(limit_ff) << FRACTION_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_node_ff   <= s8_side_ff.node;
         rsp_res_ff    <= s8_side_ff.res;
         rsp_temp_ff   <= temp_in;
         rsp_over_ff   <= over_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_node_millivolts = rsp_node_ff;
   assign rsp_resistance_ohms = rsp_res_ff;
   assign rsp_temperature_q8  = rsp_temp_ff;
   assign rsp_over_limit      = rsp_over_ff;
   assign rsp_status          = rsp_status_ff;

   // checks
   a_supply_res : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SUPPLY) |-> rsp_resistance_ohms == RES_MAX)
      else $error("supply status without saturated resistance");

   a_supply_node : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_SUPPLY) ==
                    (rsp_node_millivolts >= NODE_W'(supply_ff)))
      else $error("supply status disagrees with node voltage");

   a_sat_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SAT) |->
         (rsp_temperature_q8 == TEMP_W'(TEMP_MAX)) ||
         (rsp_temperature_q8 == TEMP_W'(TEMP_MIN)))
      else $error("saturated status with unsaturated temperature");

   a_over_positive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_over_limit |-> rsp_temperature_q8 > 0)
      else $error("limit flag with non-positive temperature");

endmodule
`default_nettype wire

FILE: rtl/ntcl_div_pipe.sv
`default_nettype none
module ntcl_div_pipe #(
   parameter int NUM_W  = 21,
   parameter int DEN_W  = 10,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   // one quotient bit per stage, restoring division
   logic              valid_ff [NUM_W];
   logic [NUM_W-1:0]  work_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              valid_prev;
      logic [NUM_W-1:0]  work_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              take;
      logic [NUM_W-1:0]  work_in;
      logic [DEN_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign work_prev  = in_num;
         assign rem_prev   = in_rem;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign work_prev  = work_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // trial subtract of the divisor
      assign trial   = {rem_prev, work_prev[NUM_W-1]};
      assign take    = (trial >= {1'b0, den_prev});
      assign rem_in  = take ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
      assign work_in = {work_prev[NUM_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            work_ff[k] <= work_in;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = work_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule
`default_nettype wire

FILE: rtl/ntcl_log2_pipe.sv
`default_nettype none
module ntcl_log2_pipe #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [ntcl_pkg::RES_W-1:0] in_value,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [ntcl_pkg::LOG_W-1:0] out_log,
   output logic [SIDE_W-1:0]          out_side
);
   import ntcl_pkg::*;

   localparam int STEPS = 24;

   // msb search
   logic              pos_valid_ff;
   logic [4:0]        pos_ff;
   logic [RES_W-1:0]  pos_value_ff;
   logic [SIDE_W-1:0] pos_side_ff;
   logic [4:0]        pos_in;

   always_comb begin
      pos_in = '0;
      for (int i = 0; i < RES_W; i++) begin
         if (in_value[i]) begin
            pos_in = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff <= 1'b0;
      end else if (advance) begin
         pos_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_ff       <= pos_in;
         pos_value_ff <= in_value;
         pos_side_ff  <= in_side;
      end
   end

   // normalise mantissa to q1.31
   logic              norm_valid_ff;
   logic [4:0]        norm_pos_ff;
   logic [31:0]       norm_mant_ff;
   logic [SIDE_W-1:0] norm_side_ff;
   logic [31:0]       norm_mant_in;

   assign norm_mant_in = 32'(pos_value_ff) << (5'd31 - pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_valid_ff <= 1'b0;
      end else if (advance) begin
         norm_valid_ff <= pos_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         norm_pos_ff  <= pos_ff;
         norm_mant_ff <= norm_mant_in;
         norm_side_ff <= pos_side_ff;
      end
   end

   // square and compare, one fraction bit per stage
   logic              sq_valid_ff [STEPS];
   logic [4:0]        sq_pos_ff   [STEPS];
   logic [31:0]       sq_mant_ff  [STEPS];
   logic [23:0]       sq_frac_ff  [STEPS];
   logic [SIDE_W-1:0] sq_side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_sq
      logic              valid_prev;
      logic [4:0]        pos_prev;
      logic [31:0]       mant_prev;
      logic [23:0]       frac_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [63:0]       square;
      logic [32:0]       scaled;
      logic [31:0]       mant_in;
      logic [23:0]       frac_in;

      if (k == 0) begin : g_first
         assign valid_prev = norm_valid_ff;
         assign pos_prev   = norm_pos_ff;
         assign mant_prev  = norm_mant_ff;
         assign frac_prev  = '0;
         assign side_prev  = norm_side_ff;
      end else begin : g_next
         assign valid_prev = sq_valid_ff[k-1];
         assign pos_prev   = sq_pos_ff[k-1];
         assign mant_prev  = sq_mant_ff[k-1];
         assign frac_prev  = sq_frac_ff[k-1];
         assign side_prev  = sq_side_ff[k-1];
      end

      assign square  = 64'(mant_prev) * 64'(mant_prev);
      assign scaled  = square[63:31];
      assign mant_in = scaled[32] ? scaled[32:1] : scaled[31:0];
      assign frac_in = {frac_prev[22:0], scaled[32]};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            sq_valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_pos_ff[k]  <= pos_prev;
            sq_mant_ff[k] <= mant_in;
            sq_frac_ff[k] <= frac_in;
            sq_side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = sq_valid_ff[STEPS-1];
   assign out_log   = {sq_pos_ff[STEPS-1], sq_frac_ff[STEPS-1]};
   assign out_side  = sq_side_ff[STEPS-1];

endmodule
`default_nettype wire

FILE: tb/ntc_temperature_with_limit_checker.sv
`default_nettype none
module ntc_temperature_with_limit_checker
   import ntcl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic [9:0]               req_adc_sample,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic [NODE_W-1:0]        rsp_node_millivolts,
   input  wire logic [RES_W-1:0]         rsp_resistance_ohms,
   input  wire logic signed [TEMP_W-1:0] rsp_temperature_q8,
   input  wire logic                     rsp_over_limit,
   input  wire logic [1:0]               rsp_status,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   output int                            failures,
   output int                            readings_pending,
   output int                            readings_checked,
   output int                            saturated_seen,
   output int                            supply_hits_seen,
   output int                            over_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [NODE_W-1:0]        node;
      logic [RES_W-1:0]         res;
      logic signed [TEMP_W-1:0] temp;
      logic                     over;
      status_type               status;
   } reading_type;

   localparam int FRAC = FRACTION_BITS_DEFAULT;

   reading_type readings_due[$];
   logic [REF_W-1:0]   ref_count;
   logic [SUP_W-1:0]   supply_mv;
   logic [LIMIT_W-1:0] limit_deg;

   // log2 in q.24 by repeated squaring of the mantissa
   function automatic longint unsigned log2_fixed(input longint unsigned r);
      longint unsigned m;
      longint unsigned frac;
      int              p;
      p = 0;
      frac = 0;
      for (int i = 0; i < 32; i++) begin
         if (r[i]) begin
            p = i;
         end
      end
      m = r << (31 - p);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (longint'(p) << 24) | frac;
   endfunction

   // full conversion of one adc sample under the current settings
   function automatic reading_type convert_sample(input logic [9:0] adc);
      reading_type     rd;
      longint unsigned node, res, mag, s;
      longint          d, x, tk, v, q;
      logic            sat;
      sat = 1'b0;
      rd.status = STATUS_OK;
      if (ref_count == 0) begin
         node = 65535;
      end else begin
         node = (64'd1250 * adc) / ref_count;
         if (node > 65535) begin
            node = 65535;
         end
      end
      if (node >= supply_mv) begin
         rd.status = STATUS_SUPPLY;
         res = 24'hFFFFFF;
      end else begin
         res = (node * 100000) / (supply_mv - node);
         if (res > 24'hFFFFFF) begin
            res = 24'hFFFFFF;
         end
      end
      if (res == 0) begin
         q = 32767;
         sat = 1'b1;
      end else begin
         d = longint'(log2_fixed(res)) - longint'(log2_fixed(100000));
         mag = (d < 0) ? -d : d;
         s = (mag * 64'd49393313039) >> 32;
         x = 64'sd3687780070 + ((d < 0) ? -longint'(s) : longint'(s));
         if (x <= 0) begin
            q = 32767;
            sat = 1'b1;
         end else begin
            tk = longint'((64'h1 << 60) / longint'(unsigned'(x)));
            v = tk - 64'sd285894246;
            // arithmetic shift floors towards minus infinity
            q = (v + (64'sd1 << (19 - FRAC))) >>> (20 - FRAC);
            if (q > 32767) begin
               q = 32767;
               sat = 1'b1;
            end else if (q < -32768) begin
               q = -32768;
               sat = 1'b1;
            end
         end
      end
      if (rd.status == STATUS_OK && sat) begin
         rd.status = STATUS_SAT;
      end
      rd.node = node[15:0];
      rd.res = res[23:0];
      rd.temp = q[15:0];
      rd.over = (q > (longint'(limit_deg) << FRAC));
      return rd;
   endfunction

   assign readings_pending = readings_due.size();

   // settings shadow, requests into the queue, results against its head
   always @(posedge clock) begin
      reading_type want;
      int          errs;
      if (reset) begin
         ref_count <= 10'd384;
         supply_mv <= 13'd4500;
         limit_deg <= 7'd30;
         readings_due.delete();
         failures <= 0;
         readings_checked <= 0;
         saturated_seen <= 0;
         supply_hits_seen <= 0;
         over_seen <= 0;
      end else begin
         errs = 0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REFERENCE_COUNT: begin
                  ref_count <= csr_data[REF_W-1:0];
               end
               CSR_SUPPLY_MILLIVOLTS: begin
                  supply_mv <= csr_data[SUP_W-1:0];
               end
               CSR_UPPER_LIMIT: begin
                  limit_deg <= csr_data[LIMIT_W-1:0];
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            readings_due.push_back(convert_sample(req_adc_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               $display("%0t: unexpected item node %0d", $time, rsp_node_millivolts);
               errs++;
            end else begin
               want = readings_due.pop_front();
               readings_checked <= readings_checked + 1;
               if (want.status == STATUS_SAT) saturated_seen <= saturated_seen + 1;
               if (want.status == STATUS_SUPPLY) supply_hits_seen <= supply_hits_seen + 1;
               if (want.over) over_seen <= over_seen + 1;
               if (rsp_node_millivolts !== want.node) begin
                  $display("%0t: node expected %0d actual %0d", $time, want.node,
                           rsp_node_millivolts);
                  errs++;
               end
               if (rsp_resistance_ohms !== want.res) begin
                  $display("%0t: resistance expected %0d actual %0d", $time, want.res,
                           rsp_resistance_ohms);
                  errs++;
               end
               if (rsp_temperature_q8 !== want.temp) begin
                  $display("%0t: temperature expected %0d actual %0d", $time, want.temp,
                           rsp_temperature_q8);
                  errs++;
               end
               if (rsp_over_limit !== want.over) begin
                  $display("%0t: over_limit expected %0b actual %0b", $time, want.over,
                           rsp_over_limit);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  errs++;
               end
            end
         end
         if (errs != 0) begin
            failures <= failures + errs;
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/ntc_temperature_with_limit_tb.sv
`default_nettype none
module ntc_temperature_with_limit_tb;
   import ntcl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 119;
   localparam longint CYCLE_LIMIT = 1_500_000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [9:0] req_adc_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic [NODE_W-1:0] rsp_node_millivolts;
   logic [RES_W-1:0] rsp_resistance_ohms;
   logic signed [TEMP_W-1:0] rsp_temperature_q8;
   logic rsp_over_limit;
   logic [1:0] rsp_status;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int failures, readings_pending, readings_checked;
   int saturated_seen, supply_hits_seen, over_seen;
   longint cycle_count;
   logic long_hold;
   int samples_sent;

   ntc_temperature_with_limit uut (
      .clock, .reset, .req_valid, .req_stall, .req_adc_sample,
      .rsp_valid, .rsp_stall, .rsp_node_millivolts, .rsp_resistance_ohms,
      .rsp_temperature_q8, .rsp_over_limit, .rsp_status,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   ntc_temperature_with_limit_checker watcher (
      .clock, .reset, .req_valid, .req_stall, .req_adc_sample,
      .rsp_valid, .rsp_stall, .rsp_node_millivolts, .rsp_resistance_ohms,
      .rsp_temperature_q8, .rsp_over_limit, .rsp_status,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .failures, .readings_pending, .readings_checked,
      .saturated_seen, .supply_hits_seen, .over_seen
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver stall pattern: random modes, plus a long hold on request
   initial begin
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 200);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            if (long_hold) begin
               rsp_stall <= 1'b1;
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 1) == 0);
                  default: rsp_stall <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   // offer one item and wait for it to be taken
   task automatic send_sample(input logic [9:0] adc);
      req_valid <= 1'b1;
      req_adc_sample <= adc;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      samples_sent++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      req_adc_sample <= 10'($urandom);
   endtask

   // drain, then let the pipeline settle before touching the registers
   task automatic drain_pipeline();
      drop_valid();
      @(posedge clock);
      while (readings_pending != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // leaves csr_valid high, the caller drops it after the last write
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic apply_settings(input logic [9:0] refc, input logic [12:0] sup,
                                 input logic [6:0] lim);
      drain_pipeline();
      write_register(CSR_REFERENCE_COUNT, 13'(refc));
      write_register(CSR_SUPPLY_MILLIVOLTS, sup);
      write_register(CSR_UPPER_LIMIT, 13'(lim));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // bursty random samples, mostly away from rails
   task automatic random_burst_run(input int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && left > 0; i++) begin
            case ($urandom_range(0, 5))
               0: send_sample(10'($urandom_range(0, 7)));
               1: send_sample(10'($urandom_range(1016, 1023)));
               default: send_sample(10'($urandom));
            endcase
            left--;
         end
         if ($urandom_range(0, 2) != 0) begin
            drop_valid();
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [9:0] refc;
      logic [12:0] sup;
      reset = 1'b1;
      req_valid = 1'b0;
      req_adc_sample = '0;
      csr_valid = 1'b0;
      csr_index = CSR_REFERENCE_COUNT;
      csr_data = '0;
      long_hold = 1'b0;
      samples_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rails, single bits and around the reset limit
      send_sample(10'd0);
      send_sample(10'd1023);
      for (int b = 0; b < 10; b++) begin
         send_sample(10'(1 << b));
      end
      send_sample(10'h155);
      send_sample(10'h2AA);
      send_sample(10'd307);
      send_sample(10'd330);
      send_sample(10'd1);

      // zero reference saturates the node voltage
      apply_settings(10'd0, 13'd4500, 7'd0);
      send_sample(10'd0);
      send_sample(10'd512);
      // extremes: tiny supply, largest supply, and a limit of 99
      apply_settings(10'd1, 13'd1, 7'd99);
      send_sample(10'd0);
      send_sample(10'd1);
      send_sample(10'd1023);
      apply_settings(10'd1023, 13'd8191, 7'd99);
      send_sample(10'd0);
      send_sample(10'd1);
      send_sample(10'd1023);
      send_sample(10'd700);

      // long receiver hold while samples keep coming
      apply_settings(10'd384, 13'd4500, 7'd30);
      fork
         begin
            long_hold <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold <= 1'b0;
         end
         random_burst_run(300);
      join

      // random phases under varied settings
      for (int ph = 0; ph < 6; ph++) begin
         refc = 10'($urandom_range(1, 1023));
         sup = 13'($urandom_range(1, 8191));
         if (ph == 0) refc = 10'($urandom_range(200, 600));
         if (ph == 1) sup = 13'($urandom_range(2500, 5500));
         apply_settings(refc, sup, 7'($urandom_range(0, 99)));
         random_burst_run(230);
      end

      drain_pipeline();
      $display("sent %0d samples, checked %0d results", samples_sent, readings_checked);
      $display("saturated %0d, supply hits %0d, over limit %0d",
               saturated_seen, supply_hits_seen, over_seen);
      if (failures == 0 && readings_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
